// ----- rtl/tcw_pkg.sv -----
// shared types and constants for the text console writer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;
	localparam int QDEPTH      = 2;

	localparam logic [7:0] ATTR_RESET = 8'h0F;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		K_READ,
		K_CR,
		K_LF,
		K_TAB,
		K_FF,
		K_CHAR
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [4:0] rd_row;
		logic [6:0] rd_col;
		logic       rd_ok;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_CLEAR
	} back_state_t;

endpackage

`default_nettype wire

// ----- rtl/tcw_front.sv -----
// front end: input register, decodes each item into a command
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         in_opcode,
	input  wire  [7:0]  in_char,
	input  wire  [4:0]  in_row,
	input  wire  [6:0]  in_col,
	output logic        cmd_valid,
	input  wire         cmd_ready,
	output cmd_t        cmd
);

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		dec.ch     = in_char;
		dec.rd_row = in_row;
		dec.rd_col = in_col;
		dec.rd_ok  = ({3'b0, in_row} < 8'(ROWS)) && ({2'b0, in_col} < 9'(COLUMNS));
		if (in_opcode == OP_READ) begin
			dec.kind = K_READ;
		end else begin
			case (in_char)
				CH_CR:   dec.kind = K_CR;
				CH_LF:   dec.kind = K_LF;
				CH_TAB:  dec.kind = K_TAB;
				CH_FF:   dec.kind = K_FF;
				default: dec.kind = K_CHAR;
			endcase
		end
	end

	assign in_ready  = !v_s1 || cmd_ready;
	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tcw_queue.sv -----
// short command queue between front and back
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue import tcw_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push_valid,
	output logic  push_ready,
	input  cmd_t  push_cmd,
	output logic  pop_valid,
	input  wire   pop,
	output cmd_t  pop_cmd
);

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	cmd_t           ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = cnt_q != (QAW+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tcw_back.sv -----
// back end: cursor, screen store with row valid bits, output register
// depends on tcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire  [7:0]   attr,
	input  wire          cmd_valid,
	output logic         cmd_pop,
	input  cmd_t         cmd,
	output logic         out_valid,
	input  wire          out_ready,
	output logic [15:0]  out_data,
	output logic [6:0]   out_col,
	output logic [4:0]   out_row,
	output logic         out_scr
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	function automatic logic [RW-1:0] wrap_row(input logic [RW:0] s);
		if (s >= (RW+1)'(ROWS)) begin
			return RW'(s - (RW+1)'(ROWS));
		end
		return RW'(s);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(COLUMNS) + AW'(c);
	endfunction

	logic [15:0] mem [CELLS];
	logic [15:0] rd_q;

	back_state_t   state_q, state_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [RW-1:0] base_q, base_d;
	logic [ROWS-1:0] vld_q, vld_d;
	logic [CW-1:0] clr_cnt_q, clr_cnt_d;
	logic [RW-1:0] prow_q, prow_d;
	logic [15:0]   cell_q, cell_d;
	logic          rd_ok_q, rd_ok_d;

	logic          out_valid_q;
	logic [15:0]   out_data_q;
	logic [6:0]    out_col_q;
	logic [4:0]    out_row_q;
	logic          out_scr_q;

	logic          out_load;
	logic [15:0]   out_data_d;
	logic          out_scr_d;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic [AW-1:0] raddr;

	logic          nl_last;
	logic [RW-1:0] nl_row;
	logic [RW-1:0] nl_base;
	logic [RW-1:0] cur_prow;
	logic [RW-1:0] rd_prow;
	logic [CW:0]   col_inc;
	logic [CW:0]   col_tab;
	logic          out_free;

	assign nl_last  = row_q == RW'(ROWS-1);
	assign nl_row   = nl_last ? row_q : row_q + 1'b1;
	assign nl_base  = nl_last ? wrap_row({1'b0, base_q} + 1'b1) : base_q;
	assign cur_prow = wrap_row({1'b0, row_q} + {1'b0, base_q});
	assign rd_prow  = wrap_row({1'b0, RW'(cmd.rd_row)} + {1'b0, base_q});
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign col_tab  = ({1'b0, col_q} + (CW+1)'(4)) & ~(CW+1)'(3);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		base_d     = base_q;
		vld_d      = vld_q;
		clr_cnt_d  = clr_cnt_q;
		prow_d     = prow_q;
		cell_d     = cell_q;
		rd_ok_d    = rd_ok_q;
		out_load   = 1'b0;
		out_data_d = '0;
		out_scr_d  = 1'b0;
		cmd_pop    = 1'b0;
		we         = 1'b0;
		waddr      = cell_addr(cur_prow, col_q);
		wdata      = {attr, cmd.ch};
		raddr      = cell_addr(rd_prow, CW'(cmd.rd_col));
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						K_READ: begin
							rd_ok_d = cmd.rd_ok && vld_q[rd_prow];
							state_d = BK_READ;
						end
						K_CR: begin
							col_d    = '0;
							out_load = 1'b1;
						end
						K_LF: begin
							col_d     = '0;
							row_d     = nl_row;
							base_d    = nl_base;
							out_scr_d = nl_last;
							if (nl_last) begin
								vld_d[base_q] = 1'b0;
							end
							out_load = 1'b1;
						end
						K_TAB: begin
							if (col_tab >= (CW+1)'(COLUMNS)) begin
								col_d     = '0;
								row_d     = nl_row;
								base_d    = nl_base;
								out_scr_d = nl_last;
								if (nl_last) begin
									vld_d[base_q] = 1'b0;
								end
							end else begin
								col_d = CW'(col_tab);
							end
							out_load = 1'b1;
						end
						K_FF: begin
							col_d    = '0;
							row_d    = '0;
							vld_d    = '0;
							out_load = 1'b1;
						end
						default: begin
							if (vld_q[cur_prow]) begin
								we = 1'b1;
								if (col_inc >= (CW+1)'(COLUMNS)) begin
									col_d     = '0;
									row_d     = nl_row;
									base_d    = nl_base;
									out_scr_d = nl_last;
									if (nl_last) begin
										vld_d[base_q] = 1'b0;
									end
								end else begin
									col_d = CW'(col_inc);
								end
								out_load = 1'b1;
							end else begin
								cell_d    = {attr, cmd.ch};
								prow_d    = cur_prow;
								clr_cnt_d = '0;
								state_d   = BK_CLEAR;
							end
						end
					endcase
				end
			end
			BK_READ: begin
				out_data_d = rd_ok_q ? rd_q : '0;
				out_load   = 1'b1;
				state_d    = BK_IDLE;
			end
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = cell_addr(prow_q, clr_cnt_q);
				wdata = (clr_cnt_q == col_q) ? cell_q : '0;
				if (clr_cnt_q == CW'(COLUMNS-1)) begin
					vld_d[prow_q] = 1'b1;
					if (col_inc >= (CW+1)'(COLUMNS)) begin
						col_d     = '0;
						row_d     = nl_row;
						base_d    = nl_base;
						out_scr_d = nl_last;
						if (nl_last) begin
							vld_d[base_q] = 1'b0;
						end
					end else begin
						col_d = CW'(col_inc);
					end
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end else begin
					clr_cnt_d = clr_cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			vld_q       <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			col_q     <= col_d;
			row_q     <= row_d;
			base_q    <= base_d;
			vld_q     <= vld_d;
			clr_cnt_q <= clr_cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prow_q  <= prow_d;
		cell_q  <= cell_d;
		rd_ok_q <= rd_ok_d;
		if (out_load) begin
			out_data_q <= out_data_d;
			out_col_q  <= 7'(col_d);
			out_row_q  <= 5'(row_d);
			out_scr_q  <= out_scr_d;
		end
	end

	// screen store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign out_scr   = out_scr_q;

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} <= (RW+1)'(ROWS-1))
		else $error("cursor row out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < (CW+1)'(COLUMNS))
		else $error("cursor column out of range");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_scr_q |-> out_row_q == 5'(ROWS-1))
		else $error("scroll reported off the last row");

	a_clear_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |-> !vld_q[prow_q] && clr_cnt_q <= CW'(COLUMNS-1))
		else $error("row sweep on a valid row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_data_q))
		else $error("result dropped before transfer");

endmodule

`default_nettype wire

// ----- rtl/text_console_writer_core.sv -----
// text console writer top level: front decode, command queue, back end
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back
// path: a put passes input register, queue and output register; a read also passes the read state
// throughput: one put per cycle unless the output stalls; a read holds the back end in its read state;
// a character landing on a row not yet written since reset, scroll or form feed first sweeps that row
// reset: cursor homed, attribute 15, row valid bits cleared so the screen reads blank at once
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero
	input  wire  [0:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // cell_data[15:0], cursor_col[22:16], cursor_row[27:23],
	                               // scrolled[28], zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_data   // text_attribute
);

	logic [7:0]  attr_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        q_valid;
	logic        q_pop;
	cmd_t        q_cmd;
	logic [15:0] out_data;
	logic [6:0]  out_col;
	logic [4:0]  out_row;
	logic        out_scr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser[0]),
		.in_char   (s_tdata[7:0]),
		.in_row    (s_tdata[12:8]),
		.in_col    (s_tdata[19:13]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_ready (cmd_ready),
		.push_cmd   (cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (q_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_col   (out_col),
		.out_row   (out_row),
		.out_scr   (out_scr)
	);

	assign m_tdata = {3'b000, out_scr, out_row, out_col, out_data};

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for text_console_writer_core: directed table, then random phases
// keeps its own screen, cursor and attribute copy and compares every result transfer
// depends on tcw_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;
	import tcw_pkg::*;

	localparam int COLS        = DEF_COLUMNS;
	localparam int ROWS_N      = DEF_ROWS;
	localparam int CELLS       = COLS * ROWS_N;
	localparam int LIMIT       = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_SHOWN   = 40;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		logic       op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} console_cmd_t;

	typedef struct {
		logic [15:0] cell_data;
		logic [6:0]  cur_col;
		logic [4:0]  cur_row;
		logic        scrolled;
	} console_resp_t;

	typedef struct {
		console_cmd_t  cmd;
		bit            known;
		console_resp_t resp;
	} console_row_t;

	typedef enum int {
		B_MIXED,
		B_LONG_LINE,
		B_READ_SWEEP,
		B_LINE_FEEDS
	} burst_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	logic [15:0]   screen_model [CELLS];
	int unsigned   col_model;
	int unsigned   row_model;
	logic [7:0]    attr_model;
	console_resp_t pending_resp [$];
	console_row_t  dir_rows [$];
	int            err_count   = 0;
	int            cycle_count = 0;
	bit            idle_on     = 1'b1;
	bit            quiet       = 1'b0;
	bit            hold_req    = 1'b0;

	text_console_writer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		if (err_count <= MAX_SHOWN) begin
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		end
	endtask

	function automatic bit advance_line();
		col_model = 0;
		row_model++;
		if (row_model >= ROWS_N) begin
			for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
			row_model = ROWS_N - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic console_resp_t console_apply(input console_cmd_t c);
		console_resp_t r;
		r.cell_data = '0;
		r.scrolled  = 1'b0;
		if (c.op == OP_READ) begin
			if (c.row < ROWS_N && c.col < COLS) r.cell_data = screen_model[c.row * COLS + c.col];
		end else begin
			case (c.ch)
				CH_CR: col_model = 0;
				CH_LF: r.scrolled = advance_line();
				CH_TAB: begin
					col_model = (col_model + 4) / 4 * 4;
					if (col_model >= COLS) r.scrolled = advance_line();
				end
				CH_FF: begin
					for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
					col_model = 0;
					row_model = 0;
				end
				default: begin
					screen_model[row_model * COLS + col_model] = {attr_model, c.ch};
					col_model++;
					if (col_model >= COLS) r.scrolled = advance_line();
				end
			endcase
		end
		r.cur_col = col_model[6:0];
		r.cur_row = row_model[4:0];
		return r;
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic console_cmd_t gen_read();
		console_cmd_t c;
		c.op = OP_READ;
		c.ch = 8'($urandom);
		if ($urandom_range(0, 5) == 0) begin
			c.row = 5'($urandom);
			c.col = 7'($urandom);
		end else begin
			c.row = 5'($urandom_range(0, ROWS_N - 1));
			c.col = 7'($urandom_range(0, COLS - 1));
		end
		return c;
	endfunction

	function automatic console_cmd_t gen_put(input burst_t kind);
		console_cmd_t c;
		int k;
		c.op  = OP_PUT;
		c.row = 5'($urandom);
		c.col = 7'($urandom);
		k = $urandom_range(0, 999);
		case (kind)
			B_LONG_LINE:  c.ch = (k < 850) ? printable() : CH_TAB;
			B_LINE_FEEDS: c.ch = (k < 500) ? CH_LF : printable();
			default: begin
				if (k < 3) c.ch = CH_FF;
				else if (k < 550) c.ch = printable();
				else if (k < 650) c.ch = 8'($urandom);
				else if (k < 770) c.ch = CH_LF;
				else if (k < 830) c.ch = CH_CR;
				else c.ch = CH_TAB;
			end
		endcase
		return c;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_cmd(input console_row_t item);
		console_resp_t r;
		if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= item.cmd.op;
		s_tdata  <= {4'b0, item.cmd.col, item.cmd.row, item.cmd.ch};
		do @(posedge clk); while (!s_tready);
		r = console_apply(item.cmd);
		if (item.known) pending_resp.push_back(item.resp);
		else pending_resp.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_attr(input logic [7:0] value);
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		attr_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(input logic op, input logic [7:0] ch, input logic [4:0] row,
			input logic [6:0] col, input bit known, input logic [15:0] cell_data,
			input logic [6:0] cur_col, input logic [4:0] cur_row, input logic scrolled);
		console_row_t e;
		e.cmd.op            = op;
		e.cmd.ch            = ch;
		e.cmd.row           = row;
		e.cmd.col           = col;
		e.known             = known;
		e.resp.cell_data    = cell_data;
		e.resp.cur_col      = cur_col;
		e.resp.cur_row      = cur_row;
		e.resp.scrolled     = scrolled;
		dir_rows.push_back(e);
	endtask

	task automatic run_phase(input logic [7:0] attr, input int n_items, input bit idle,
			input bit hold);
		console_row_t item;
		burst_t       kind;
		int           sent;
		int           len;
		int           pick;
		int           read_pct;
		write_attr(attr);
		idle_on  = idle;
		hold_req = hold;
		sent     = 0;
		item.known = 1'b0;
		while (sent < n_items) begin
			pick  = $urandom_range(0, 9);
			kind  = (pick < 6) ? B_MIXED : (pick < 8) ? B_LONG_LINE :
				(pick < 9) ? B_READ_SWEEP : B_LINE_FEEDS;
			quiet = ($urandom_range(0, 3) == 0);
			case (kind)
				B_MIXED: begin
					len = $urandom_range(8, 40);
					read_pct = 25;
				end
				B_LONG_LINE: begin
					len = $urandom_range(60, 100);
					read_pct = 10;
				end
				B_READ_SWEEP: begin
					len = $urandom_range(10, 30);
					read_pct = 100;
				end
				default: begin
					len = $urandom_range(20, 30);
					read_pct = 10;
				end
			endcase
			for (int k = 0; k < len && sent < n_items; k++) begin
				if ($urandom_range(0, 99) < read_pct) item.cmd = gen_read();
				else item.cmd = gen_put(kind);
				send_cmd(item);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic check_result(input logic [31:0] d);
		console_resp_t e;
		if (pending_resp.size() == 0) begin
			report_mismatch("transfer with nothing pending", d, 32'h0);
		end else begin
			e = pending_resp.pop_front();
			if (d[15:0] !== e.cell_data)
				report_mismatch("cell_data", 32'(d[15:0]), 32'(e.cell_data));
			if (d[22:16] !== e.cur_col)
				report_mismatch("cursor_col", 32'(d[22:16]), 32'(e.cur_col));
			if (d[27:23] !== e.cur_row)
				report_mismatch("cursor_row", 32'(d[27:23]), 32'(e.cur_row));
			if (d[28] !== e.scrolled)
				report_mismatch("scrolled", 32'(d[28]), 32'(e.scrolled));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result(m_tdata);
	end

	// receiver side: ready bursts, random stalls, one long hold-off on request
	initial begin : sink_ctl
		int n;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				n = HOLD_CYCLES;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 16);
			end else begin
				m_tready <= 1'b1;
				n = $urandom_range(1, 40);
			end
			repeat (n) @(negedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	initial begin : main
		for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
		col_model  = 0;
		row_model  = 0;
		attr_model = ATTR_RESET;

		// directed rows, default attribute
		add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd24, 7'd79,  1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_PUT,  8'h41, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd1,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, 16'h0F41, 7'd1,  5'd0, 1'b0);
		add_row(OP_PUT,  8'hFF, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd2,  5'd0, 1'b0);
		add_row(OP_PUT,  8'h00, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd3,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd0,  7'd2,   1'b1, 16'h0F00, 7'd3,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd0,  7'd1,   1'b1, 16'h0FFF, 7'd3,  5'd0, 1'b0);
		add_row(OP_PUT,  CH_TAB, 5'd0, 7'd0,   1'b1, 16'h0000, 7'd4,  5'd0, 1'b0);
		add_row(OP_PUT,  CH_TAB, 5'd0, 7'd0,   1'b1, 16'h0000, 7'd8,  5'd0, 1'b0);
		add_row(OP_PUT,  8'h20, 5'd0,  7'd0,   1'b0, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_PUT,  CH_TAB, 5'd0, 7'd0,   1'b1, 16'h0000, 7'd12, 5'd0, 1'b0);
		add_row(OP_PUT,  CH_CR, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_PUT,  CH_LF, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd1, 1'b0);
		add_row(OP_PUT,  8'h5A, 5'd0,  7'd0,   1'b0, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd1,  7'd0,   1'b1, 16'h0F5A, 7'd1,  5'd1, 1'b0);
		add_row(OP_READ, 8'h00, 5'd0,  7'd80,  1'b1, 16'h0000, 7'd1,  5'd1, 1'b0);
		add_row(OP_READ, 8'h00, 5'd25, 7'd0,   1'b1, 16'h0000, 7'd1,  5'd1, 1'b0);
		add_row(OP_PUT,  CH_FF, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_READ, 8'h00, 5'd1,  7'd0,   1'b1, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_PUT,  8'h7F, 5'd0,  7'd0,   1'b0, 16'h0000, 7'd0,  5'd0, 1'b0);
		add_row(OP_PUT,  8'h80, 5'd31, 7'd127, 1'b0, 16'h0000, 7'd0,  5'd0, 1'b0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) send_cmd(dir_rows[i]);
		s_tvalid <= 1'b0;

		run_phase(8'h00, 300, 1'b1, 1'b0);
		run_phase(8'hFF, 300, 1'b1, 1'b1);
		run_phase(8'($urandom_range(1, 254)), 300, 1'b1, 1'b0);
		run_phase(8'($urandom_range(1, 254)), 330, 1'b0, 1'b0);

		while (pending_resp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
